// ----- design/lces_pkg.sv -----
// ----------------------------------------------------------------------------
// LED colour effect serialiser package
// Shared widths, types, effect codes and register addresses.
// ----------------------------------------------------------------------------
package lces_pkg;

  localparam int LevelW = 8;
  localparam int TickW  = 8;
  localparam int PosW   = 16;
  localparam int FuncW  = 2;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [TickW-1:0]  tick_t;
  typedef logic [PosW-1:0]   pos_t;
  typedef logic [FuncW-1:0]  func_t;

  // Effect codes
  localparam func_t FUNC_WHEEL  = 2'd0;
  localparam func_t FUNC_SOFT   = 2'd1;
  localparam func_t FUNC_BREATH = 2'd2;
  localparam func_t FUNC_NONE   = 2'd3;

  // Register indexes (byte address divided by four)
  localparam logic [2:0] REG_MAX_LEVEL  = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [2:0] REG_ONE_LOW    = 3'd2;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd4;

  // Reset values
  localparam level_t MAX_LEVEL_RST = 8'd64;
  localparam tick_t  ONE_HIGH_RST  = 8'd13;
  localparam tick_t  ONE_LOW_RST   = 8'd11;
  localparam tick_t  ZERO_HIGH_RST = 8'd6;
  localparam tick_t  ZERO_LOW_RST  = 8'd18;

  // Frame layout
  localparam int FrameBits = 3 * LevelW;

endpackage

// ----- design/lces_if.sv -----
// ----------------------------------------------------------------------------
// LED colour effect serialiser channels
// Command channel (effect and position) and symbol channel (one line bit).
// ----------------------------------------------------------------------------
interface lces_cmd_if;
  import lces_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  pos_t  position;

  modport source (output valid, output func, output position, input ready);
  modport sink   (input valid, input func, input position, output ready);
endinterface

interface lces_sym_if;
  import lces_pkg::*;

  logic   valid;
  logic   ready;
  logic   line_bit;
  tick_t  high_ticks;
  tick_t  low_ticks;
  level_t red_level;
  level_t green_level;
  level_t blue_level;
  logic   last_bit;

  modport source (output valid, output line_bit, output high_ticks, output low_ticks,
                  output red_level, output green_level, output blue_level,
                  output last_bit, input ready);
  modport sink   (input valid, input line_bit, input high_ticks, input low_ticks,
                  input red_level, input green_level, input blue_level,
                  input last_bit, output ready);
endinterface

// ----- design/led_color_effect_serializer.sv -----
// ----------------------------------------------------------------------------
// LED colour effect serialiser
// After a command is taken, a 16-step bit-serial reduction of the position
// runs in ST_DIV, the levels step in ST_UPD and the 24 symbol words go out
// in ST_SEND; a new command is taken only once the sequencer is back in idle.
// Reset (rst, synchronous): channels clear to zero, registers take defaults.
// Commands with the unused effect code, or a breath position in the last
// third, are absorbed with no symbol words.
// ----------------------------------------------------------------------------
module led_color_effect_serializer (
  input  logic                     clk,
  input  logic                     rst,
  lces_cmd_if.sink                 cmd,
  lces_sym_if.source               sym,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [lces_pkg::AddrW-1:0] paddr,
  input  logic [lces_pkg::DataW-1:0] pwdata,
  output logic [lces_pkg::DataW-1:0] prdata,
  output logic                     pready
);
  import lces_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  localparam int RemW = LevelW + 2;

  // Configuration registers
  level_t max_level;
  tick_t  one_high_ticks;
  tick_t  one_low_ticks;
  tick_t  zero_high_ticks;
  tick_t  zero_low_ticks;

  // Control and datapath registers
  logic [1:0]           state;
  logic [4:0]           cnt;
  func_t                func;
  pos_t                 pos_sh;
  logic [RemW-1:0]      rem;
  level_t               red_now;
  level_t               green_now;
  level_t               blue_now;
  logic [FrameBits-1:0] frame;

  logic [RemW-1:0]      period;
  logic [RemW:0]        trial;
  logic [RemW-1:0]      q;
  logic [RemW-1:0]      m10;
  logic [RemW-1:0]      m2;
  logic [15:0]          third_prod;
  logic [RemW-1:0]      floor_lvl;
  logic [RemW-1:0]      tr;
  logic [RemW-1:0]      tg;
  logic [RemW-1:0]      tb;
  logic                 skip;
  level_t               red_next;
  level_t               green_next;
  level_t               blue_next;
  logic                 wr_en;
  logic [2:0]           reg_idx;

  function automatic level_t approach(input level_t cur, input level_t target);
    level_t res;
    res = cur;
    if (target > cur) begin
      res = cur + 8'd1;
    end else if (target < cur) begin
      res = cur - 8'd1;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level       <= MAX_LEVEL_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      one_low_ticks   <= ONE_LOW_RST;
      zero_high_ticks <= ZERO_HIGH_RST;
      zero_low_ticks  <= ZERO_LOW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_LEVEL: max_level       <= pwdata[LevelW-1:0];
        REG_ONE_HIGH:  one_high_ticks  <= pwdata[TickW-1:0];
        REG_ONE_LOW:   one_low_ticks   <= pwdata[TickW-1:0];
        REG_ZERO_HIGH: zero_high_ticks <= pwdata[TickW-1:0];
        REG_ZERO_LOW:  zero_low_ticks  <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_LEVEL: prdata = {{(DataW-LevelW){1'b0}}, max_level};
      REG_ONE_HIGH:  prdata = {{(DataW-TickW){1'b0}}, one_high_ticks};
      REG_ONE_LOW:   prdata = {{(DataW-TickW){1'b0}}, one_low_ticks};
      REG_ZERO_HIGH: prdata = {{(DataW-TickW){1'b0}}, zero_high_ticks};
      REG_ZERO_LOW:  prdata = {{(DataW-TickW){1'b0}}, zero_low_ticks};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Position reduction and colour targets
  // --------------------------------------------------------------------------
  assign m10    = {2'b00, max_level};
  assign m2     = {m10[RemW-2:0], 1'b0};
  assign period = m2 + m10;

  // One restoring step per cycle, position bits entering MSB first
  assign trial = {rem, pos_sh[PosW-1]};

  // A zero period takes the reduced position as zero
  assign q = (max_level == '0) ? '0 : rem;

  // m/3 as a multiply by 171/512, exact over the 8-bit range
  assign third_prod = {8'd0, max_level} * 16'd171;
  assign floor_lvl  = {3'b000, third_prod[15:9]};

  always_comb begin
    tr   = '0;
    tg   = '0;
    tb   = '0;
    skip = 1'b0;
    if (func == FUNC_BREATH) begin
      if (q < m10) begin
        tr = q;
      end else if (q < m2) begin
        tr = m2 - q - 10'd1;
      end else begin
        skip = 1'b1;
      end
      tg = tr;
      tb = tr;
    end else begin
      if (q < m10) begin
        tr = (func == FUNC_SOFT) ? floor_lvl : '0;
        tg = m10 - q;
        tb = q;
      end else if (q < m2) begin
        tr = q - m10;
        tg = (func == FUNC_SOFT) ? floor_lvl : '0;
        tb = m2 - q;
      end else begin
        tr = period - q;
        tg = q - m2;
        tb = (func == FUNC_SOFT) ? floor_lvl : '0;
      end
    end
  end

  assign red_next   = approach(red_now,   tr[LevelW-1:0]);
  assign green_next = approach(green_now, tg[LevelW-1:0]);
  assign blue_next  = approach(blue_now,  tb[LevelW-1:0]);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      red_now   <= '0;
      green_now <= '0;
      blue_now  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid && (cmd.func != FUNC_NONE)) begin
            state <= ST_DIV;
            cnt   <= '0;
          end
        end
        ST_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt[3:0] == 4'hF) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          cnt <= '0;
          if (skip) begin
            state <= ST_IDLE;
          end else begin
            red_now   <= red_next;
            green_now <= green_next;
            blue_now  <= blue_next;
            state     <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (sym.ready) begin
            cnt <= cnt + 5'd1;
            if (cnt == 5'(FrameBits - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      func   <= cmd.func;
      pos_sh <= cmd.position;
      rem    <= '0;
    end
    if (state == ST_DIV) begin
      pos_sh <= {pos_sh[PosW-2:0], 1'b0};
      if (trial >= {1'b0, period}) begin
        rem <= RemW'(trial - {1'b0, period});
      end else begin
        rem <= trial[RemW-1:0];
      end
    end
    if (state == ST_UPD) begin
      frame <= {green_next, red_next, blue_next};
    end else if (state == ST_SEND && sym.ready) begin
      frame <= {frame[FrameBits-2:0], 1'b0};
    end
  end

  assign cmd.ready = (state == ST_IDLE);

  assign sym.valid       = (state == ST_SEND);
  assign sym.line_bit    = frame[FrameBits-1];
  assign sym.high_ticks  = frame[FrameBits-1] ? one_high_ticks : zero_high_ticks;
  assign sym.low_ticks   = frame[FrameBits-1] ? one_low_ticks : zero_low_ticks;
  assign sym.red_level   = red_now;
  assign sym.green_level = green_now;
  assign sym.blue_level  = blue_now;
  assign sym.last_bit    = (cnt == 5'(FrameBits - 1));

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && sym.valid))
    else $error("command taken while a frame is still being sent");

  a_reduce_first: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !sym.valid)
    else $error("symbol word offered before the position was reduced");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (sym.valid && sym.ready && sym.last_bit) |=> cmd.ready)
    else $error("sequencer did not return to idle after the last word");

  a_levels_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPD) |=> (red_now == $past(red_now) && green_now == $past(green_now)
                           && blue_now == $past(blue_now)))
    else $error("channel level changed outside the update step");

  a_frame_length: assert property (@(posedge clk) disable iff (rst)
    (sym.valid && sym.last_bit) |-> (cnt == 5'(FrameBits - 1)))
    else $error("last word flag out of step with the bit count");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED colour effect serialiser testbench
// Drives effect commands and register writes, and predicts the channel levels
// and the 24 line symbol words of every frame. Each symbol word is checked
// field by field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lces_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 200;
  localparam int LongHold    = 600;

  typedef struct {
    logic   line_bit;
    tick_t  high_ticks;
    tick_t  low_ticks;
    level_t red_level;
    level_t green_level;
    level_t blue_level;
    logic   last_bit;
  } symbol_t;

  typedef enum {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_EVERY_THIRD} rx_mode_t;

  class led_frame_checker;
    level_t  max_level;
    tick_t   one_high;
    tick_t   one_low;
    tick_t   zero_high;
    tick_t   zero_low;
    level_t  red_now;
    level_t  green_now;
    level_t  blue_now;
    symbol_t pending_symbols[$];
    int      errors;
    int      word_count;

    function new();
      max_level  = MAX_LEVEL_RST;
      one_high   = ONE_HIGH_RST;
      one_low    = ONE_LOW_RST;
      zero_high  = ZERO_HIGH_RST;
      zero_low   = ZERO_LOW_RST;
      red_now    = '0;
      green_now  = '0;
      blue_now   = '0;
      errors     = 0;
      word_count = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    function void set_register(logic [2:0] idx, logic [DataW-1:0] value);
      case (idx)
        REG_MAX_LEVEL: max_level = value[7:0];
        REG_ONE_HIGH:  one_high  = value[7:0];
        REG_ONE_LOW:   one_low   = value[7:0];
        REG_ZERO_HIGH: zero_high = value[7:0];
        REG_ZERO_LOW:  zero_low  = value[7:0];
        default: ;
      endcase
    endfunction

    function int register_value(logic [2:0] idx);
      case (idx)
        REG_MAX_LEVEL: return max_level;
        REG_ONE_HIGH:  return one_high;
        REG_ONE_LOW:   return one_low;
        REG_ZERO_HIGH: return zero_high;
        REG_ZERO_LOW:  return zero_low;
        default:       return 0;
      endcase
    endfunction

    function level_t step_toward(level_t now, int target);
      if (target > now) return now + 8'd1;
      if (target < now) return now - 8'd1;
      return now;
    endfunction

    function int pending();
      return pending_symbols.size();
    endfunction

    // Works out the colour targets, moves each channel one step and queues the
    // 24 symbol words of a frame, except for the unused effect and breath's last third.
    function void take_command(func_t f, pos_t p);
      int      m;
      int      period;
      int      q;
      int      t_red;
      int      t_green;
      int      t_blue;
      int      floor_level;
      level_t  frame_bytes[3];
      symbol_t s;
      m      = max_level;
      period = 3 * m;
      q      = (period != 0) ? (int'(p) % period) : 0;
      if (f == FUNC_NONE) return;
      if (f == FUNC_BREATH) begin
        if (q < m) t_red = q;
        else if (q < 2 * m) t_red = 2 * m - q - 1;
        else return;
        t_green = t_red;
        t_blue  = t_red;
      end else begin
        floor_level = (f == FUNC_SOFT) ? (m / 3) : 0;
        if (q < m) begin
          t_red = floor_level; t_green = m - q; t_blue = q;
        end else if (q < 2 * m) begin
          t_red = q - m; t_green = floor_level; t_blue = 2 * m - q;
        end else begin
          t_red = period - q; t_green = q - 2 * m; t_blue = floor_level;
        end
      end
      red_now   = step_toward(red_now, t_red & 8'hFF);
      green_now = step_toward(green_now, t_green & 8'hFF);
      blue_now  = step_toward(blue_now, t_blue & 8'hFF);
      frame_bytes[0] = green_now;
      frame_bytes[1] = red_now;
      frame_bytes[2] = blue_now;
      for (int b = 0; b < 3; b++) begin
        for (int i = 0; i < LevelW; i++) begin
          s.line_bit    = frame_bytes[b][LevelW-1-i];
          s.high_ticks  = s.line_bit ? one_high : zero_high;
          s.low_ticks   = s.line_bit ? one_low : zero_low;
          s.red_level   = red_now;
          s.green_level = green_now;
          s.blue_level  = blue_now;
          s.last_bit    = (b == 2) && (i == LevelW - 1);
          pending_symbols.push_back(s);
        end
      end
    endfunction

    task check_symbol(symbol_t got);
      symbol_t want;
      if (pending_symbols.size() == 0) begin
        report($sformatf("symbol word %0d arrived with no frame pending", word_count));
      end else begin
        want = pending_symbols.pop_front();
        check_field("line_bit", got.line_bit, want.line_bit);
        check_field("high_ticks", got.high_ticks, want.high_ticks);
        check_field("low_ticks", got.low_ticks, want.low_ticks);
        check_field("red_level", got.red_level, want.red_level);
        check_field("green_level", got.green_level, want.green_level);
        check_field("blue_level", got.blue_level, want.blue_level);
        check_field("last_bit", got.last_bit, want.last_bit);
      end
      word_count++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  lces_cmd_if cmd_if ();
  lces_sym_if sym_if ();

  led_frame_checker led_frames;
  int   cycle_count = 0;
  int   burst_left  = 0;
  logic hold_request = 1'b0;

  led_color_effect_serializer DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .sym     (sym_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Symbol words are checked before the command of the same edge is noted,
  // so that the order of the two within a time step never matters.
  always @(posedge clk) begin : monitor
    symbol_t got;
    if (!rst && sym_if.valid && sym_if.ready) begin
      got.line_bit    = sym_if.line_bit;
      got.high_ticks  = sym_if.high_ticks;
      got.low_ticks   = sym_if.low_ticks;
      got.red_level   = sym_if.red_level;
      got.green_level = sym_if.green_level;
      got.blue_level  = sym_if.blue_level;
      got.last_bit    = sym_if.last_bit;
      led_frames.check_symbol(got);
    end
    if (!rst && cmd_if.valid && cmd_if.ready)
      led_frames.take_command(cmd_if.func, cmd_if.position);
  end

  // Receiver: stall pattern changes now and then; a long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    mode      = RX_STREAM;
    mode_left = 0;
    hold_left = 0;
    sym_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = LongHold;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        sym_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STREAM:      sym_if.ready <= 1'b1;
          RX_LIGHT:       sym_if.ready <= ($urandom_range(0, 9) < 7);
          RX_HEAVY:       sym_if.ready <= ($urandom_range(0, 9) < 3);
          RX_EVERY_THIRD: sym_if.ready <= (cycle_count % 3 != 0);
          default:        sym_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // The sender works in bursts; a gap of zero keeps valid high.
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return $urandom_range(1, 45);
  endfunction

  task automatic drive_command(func_t f, pos_t p);
    int gap;
    cmd_if.valid    <= 1'b1;
    cmd_if.func     <= f;
    cmd_if.position <= p;
    do @(posedge clk); while (!cmd_if.ready);
    gap = next_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apb_access(logic [2:0] idx, logic write_en, logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (write_en) led_frames.set_register(idx, data);
    else led_frames.check_field($sformatf("register %0d readback", idx), prdata,
                                led_frames.register_value(idx));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int m, int one_hi, int one_lo, int zero_hi, int zero_lo);
    apb_access(REG_MAX_LEVEL, 1'b1, m);
    apb_access(REG_ONE_HIGH, 1'b1, one_hi);
    apb_access(REG_ONE_LOW, 1'b1, one_lo);
    apb_access(REG_ZERO_HIGH, 1'b1, zero_hi);
    apb_access(REG_ZERO_LOW, 1'b1, zero_lo);
    apb_access(REG_MAX_LEVEL, 1'b0, '0);
    apb_access(REG_ONE_HIGH, 1'b0, '0);
    apb_access(REG_ONE_LOW, 1'b0, '0);
    apb_access(REG_ZERO_HIGH, 1'b0, '0);
    apb_access(REG_ZERO_LOW, 1'b0, '0);
  endtask

  // Commands that yield no word may still be in flight once the last word
  // has come, so a settling pause follows.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (led_frames.pending() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  // Mostly animation sweeps, where the position creeps forward and the
  // channels track their targets; the rest is scattered and unused effects.
  task automatic random_commands(int count);
    int    done;
    int    run_left;
    int    pick;
    func_t run_func;
    pos_t  run_pos;
    func_t f;
    pos_t  p;
    done     = 0;
    run_left = 0;
    run_func = FUNC_WHEEL;
    run_pos  = '0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if (run_left == 0) begin
          run_left = $urandom_range(8, 40);
          run_func = func_t'($urandom_range(0, 2));
          run_pos  = pos_t'($urandom);
        end
        run_left--;
        if ($urandom_range(0, 4) == 0) run_pos += pos_t'($urandom_range(2, 9));
        else run_pos += 16'd1;
        f = run_func;
        p = run_pos;
      end else if (pick < 92) begin
        f = func_t'($urandom_range(0, 2));
        p = pos_t'($urandom);
      end else begin
        f = FUNC_NONE;
        p = pos_t'($urandom);
      end
      drive_command(f, p);
      if (f != FUNC_NONE) done++;
    end
  endtask

  initial begin : stimulus
    func_t dir_func[];
    pos_t  dir_pos[];
    int    m;
    dir_func = '{FUNC_WHEEL, FUNC_WHEEL, FUNC_WHEEL, FUNC_WHEEL, FUNC_WHEEL,
                 FUNC_WHEEL, FUNC_WHEEL, FUNC_WHEEL, FUNC_SOFT, FUNC_SOFT,
                 FUNC_SOFT, FUNC_SOFT, FUNC_BREATH, FUNC_BREATH, FUNC_BREATH,
                 FUNC_BREATH, FUNC_BREATH, FUNC_BREATH, FUNC_BREATH, FUNC_NONE,
                 FUNC_NONE};
    dir_pos  = '{16'd0, 16'd63, 16'd64, 16'd127, 16'd128, 16'd191, 16'd192,
                 16'd65535, 16'd0, 16'd100, 16'd150, 16'd65535, 16'd0, 16'd63,
                 16'd64, 16'd127, 16'd128, 16'd191, 16'd65535, 16'd0, 16'd65535};
    rst             <= 1'b1;
    cmd_if.valid    <= 1'b0;
    cmd_if.func     <= FUNC_WHEEL;
    cmd_if.position <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    led_frames = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset values, then the wheel thirds, their borders and the extremes, with soft, breath and unused effects.
    apb_access(REG_MAX_LEVEL, 1'b0, '0);
    apb_access(REG_ONE_HIGH, 1'b0, '0);
    apb_access(REG_ONE_LOW, 1'b0, '0);
    apb_access(REG_ZERO_HIGH, 1'b0, '0);
    apb_access(REG_ZERO_LOW, 1'b0, '0);
    foreach (dir_func[i]) drive_command(dir_func[i], dir_pos[i]);
    wait_idle();

    // A zero peak level and zero symbol times.
    configure(0, 0, 0, 0, 0);
    drive_command(FUNC_WHEEL, 16'd5);
    drive_command(FUNC_SOFT, 16'd1000);
    drive_command(FUNC_BREATH, 16'd7);
    drive_command(FUNC_BREATH, 16'd65535);
    drive_command(FUNC_WHEEL, 16'd65535);
    wait_idle();

    configure(1, 1, 1, 1, 1);
    random_commands(40);
    wait_idle();

    // Long hold-off on the symbol side while commands keep coming.
    configure(255, 255, 255, 255, 255);
    hold_request = 1'b1;
    burst_left   = 30;
    for (int k = 0; k < 24; k++) drive_command(FUNC_WHEEL, pos_t'(300 + k));
    random_commands(40);
    wait_idle();

    repeat (5) begin
      if ($urandom_range(0, 1) == 0) m = $urandom_range(1, 20);
      else m = $urandom_range(1, 255);
      configure(m, $urandom_range(1, 255), $urandom_range(1, 255),
                $urandom_range(1, 255), $urandom_range(1, 255));
      random_commands(40);
      wait_idle();
    end

    if (led_frames.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lces_pkg.sv
design/lces_if.sv
design/led_color_effect_serializer.sv
verif/tb_top.sv
